@@ rtl/mkd_pkg.sv @@
// types, constants and the code table of the morse key decoder
package mkd_pkg;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned NUM_LETTERS  = 26;
  localparam int unsigned MAX_CODE_LEN = 4;
  localparam int unsigned LETTER_W     = 5;

  localparam logic [CFG_W-1:0] DASH_TICKS_RST = 16'd100;
  localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd500;
  localparam logic [CFG_W-1:0] WORD_GAP_RST   = 16'd700;

  typedef enum logic [1:0] {
    REG_DASH_TICKS = 2'd0,
    REG_LETTER_GAP = 2'd1,
    REG_WORD_GAP   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_LETTER  = 2'd1,
    EV_INVALID = 2'd2,
    EV_SPACE   = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic                found;
    logic [LETTER_W-1:0] index;
  } decode_t;

  // length and dash bits of a through z, bit i set when symbol i is a dash
  localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4
  };

  localparam logic [MAX_CODE_LEN-1:0] CODE_BITS [NUM_LETTERS] = '{
    4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4,
    4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2,
    4'h3, 4'h1, 4'h7, 4'h6, 4'hB, 4'h2,
    4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9,
    4'hD, 4'h3
  };

  function automatic decode_t decode_code(input logic [2:0] len,
                                          input logic [MAX_CODE_LEN-1:0] bits);
    decode_t res;
    res.found = 1'b0;
    res.index = '0;
    for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
      if (CODE_LEN[i] == len && CODE_BITS[i] == bits) begin
        res.found = 1'b1;
        res.index = LETTER_W'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/morse_key_decoder.sv @@
// morse key decoder: press and gap timing, symbol store, letter decode
// a result is valid in the cycle after its key sample is accepted
// throughput: one key sample per cycle while sample_stall is low, set by the single state update per sample
// a held result stalls new samples only while result_stall is high
// reset: synchronous, clears counters, symbol store and result valid and
// restores the thresholds to 100, 500 and 700 ticks
module morse_key_decoder #(
  parameter int unsigned MAX_SYMBOLS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mkd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic                          key_down,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          led_on,
  output mkd_pkg::event_kind_t          event_kind,
  output logic [mkd_pkg::LETTER_W-1:0]  letter_index
);
  import mkd_pkg::*;

  localparam int unsigned SC_W = $clog2(MAX_SYMBOLS + 1);
  localparam logic [SC_W-1:0] SC_MAX  = SC_W'(MAX_SYMBOLS);
  localparam logic [SC_W-1:0] SC_CODE = SC_W'(MAX_CODE_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  logic [CFG_W-1:0] dash_ticks;
  logic [CFG_W-1:0] letter_gap;
  logic [CFG_W-1:0] word_gap;

  logic [CNT_W-1:0]        press_count, press_count_next;
  logic [CNT_W-1:0]        gap_count, gap_count_next;
  logic                    was_pressed, was_pressed_next;
  logic                    letter_done, letter_done_next;
  logic                    dash_flag, dash_flag_next;
  logic [MAX_CODE_LEN-1:0] symbol_bits, symbol_bits_next;
  logic [SC_W-1:0]         symbol_count, symbol_count_next;

  event_kind_t             kind_next;
  logic [LETTER_W-1:0]     letter_next;
  decode_t                 dec;
  logic                    accept;

  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_ticks <= DASH_TICKS_RST;
      letter_gap <= LETTER_GAP_RST;
      word_gap   <= WORD_GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DASH_TICKS: dash_ticks <= cfg_data;
        REG_LETTER_GAP: letter_gap <= cfg_data;
        REG_WORD_GAP:   word_gap   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    press_count_next  = press_count;
    gap_count_next    = gap_count;
    was_pressed_next  = was_pressed;
    letter_done_next  = letter_done;
    symbol_bits_next  = symbol_bits;
    symbol_count_next = symbol_count;
    kind_next         = EV_NONE;
    letter_next       = '0;
    dec               = '0;

    if (!key_down) begin
      press_count_next = '0;
      if (gap_count != CNT_SAT) begin
        gap_count_next = gap_count + CNT_W'(1);
      end
      if (was_pressed) begin
        was_pressed_next = 1'b0;
        if (symbol_count < SC_MAX) begin
          if (dash_flag && symbol_count < SC_CODE) begin
            symbol_bits_next[symbol_count[1:0]] = 1'b1;
          end
          symbol_count_next = symbol_count + SC_W'(1);
        end
      end
    end else begin
      gap_count_next   = '0;
      letter_done_next = 1'b0;
      was_pressed_next = 1'b1;
      if (press_count != CNT_SAT) begin
        press_count_next = press_count + CNT_W'(1);
      end
    end

    // decode the store when the gap reaches letter_gap; letter_done holds it off until a key press or a word space
    if (letter_gap <= gap_count_next && gap_count_next <= word_gap && !letter_done_next) begin
      if (symbol_count_next != '0 && symbol_count_next <= SC_CODE) begin
        dec = decode_code(symbol_count_next[2:0], symbol_bits_next);
      end
      press_count_next = '0;
      if (dec.found) begin
        kind_next   = EV_LETTER;
        letter_next = dec.index;
      end else begin
        kind_next = EV_INVALID;
      end
      symbol_bits_next  = '0;
      symbol_count_next = '0;
      letter_done_next  = 1'b1;
    end

    if (gap_count_next > word_gap) begin
      press_count_next = '0;
      gap_count_next   = '0;
      letter_done_next = 1'b0;
      kind_next        = EV_SPACE;
      letter_next      = '0;
    end

    dash_flag_next = press_count_next > dash_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count  <= '0;
      gap_count    <= '0;
      was_pressed  <= 1'b0;
      letter_done  <= 1'b0;
      dash_flag    <= 1'b0;
      symbol_bits  <= '0;
      symbol_count <= '0;
    end else if (accept) begin
      press_count  <= press_count_next;
      gap_count    <= gap_count_next;
      was_pressed  <= was_pressed_next;
      letter_done  <= letter_done_next;
      dash_flag    <= dash_flag_next;
      symbol_bits  <= symbol_bits_next;
      symbol_count <= symbol_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_on       <= dash_flag_next;
      event_kind   <= kind_next;
      letter_index <= letter_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted sample produced no result");

  a_letter_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_kind == EV_LETTER |-> letter_index < LETTER_W'(NUM_LETTERS))
    else $error("letter index out of range");

  a_symbol_count_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count <= SC_MAX)
    else $error("symbol count beyond its limit");

  a_space_clears_gap: assert property (@(posedge clk) disable iff (rst)
    accept && kind_next == EV_SPACE |=> gap_count == '0 && press_count == '0 && !dash_flag)
    else $error("word space did not restart the counters");

  a_led_matches_flag: assert property (@(posedge clk) disable iff (rst)
    accept |=> led_on == dash_flag)
    else $error("led disagrees with the dash flag");
`endif

endmodule
